// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define TESL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TESL_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/tesl_pkg.sv
// ----------------------------------------------------------------------------
// tesl_pkg
// Shared constants, register codes and interpolation tables.
// ----------------------------------------------------------------------------
`default_nettype none

package tesl_pkg;

  localparam int FRAC_BITS       = 15;
  localparam int LOG_TABLE_DEPTH = 64;
  localparam int LOG2D           = $clog2(LOG_TABLE_DEPTH);

  localparam int DUTY_W   = FRAC_BITS + 2;
  localparam int L_W      = $clog2(FRAC_BITS + 1) + 16;
  localparam int SHAPED_W = FRAC_BITS + 2;
  localparam int WIDE_W   = FRAC_BITS + 5;
  localparam int MUL_A_W  = (L_W > SHAPED_W) ? ((L_W > 18) ? L_W : 18)
                                             : ((SHAPED_W > 18) ? SHAPED_W : 18);
  localparam int MUL_B_W  = 16;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE    = 3'd4;

  typedef logic [17:0] tab_t [0:LOG_TABLE_DEPTH];

  // Truncating log2 of a Q16 mantissa by repeated squaring.
  function automatic logic [15:0] sq_log2(input logic [16:0] u);
    logic [35:0] y;
    logic [15:0] r;
    y = 36'(u);
    r = '0;
    for (int k = 15; k >= 0; k--) begin
      y = (y * y) >> 16;
      if (y >= 36'd131072) begin
        y = y >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic tab_t make_lg_tab();
    tab_t t;
    logic [16:0] tgt;
    for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
      tgt = 17'(i) << (16 - LOG2D);
      if (i == LOG_TABLE_DEPTH) t[i] = 18'd65536;
      else t[i] = 18'(sq_log2(17'd65536 + tgt));
    end
    return t;
  endfunction

  // Largest mantissa whose log2 does not exceed each table point.
  function automatic tab_t make_ex_tab();
    tab_t t;
    logic [16:0] tgt;
    logic [17:0] lo;
    logic [17:0] hi;
    logic [17:0] mid;
    for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
      tgt = 17'(i) << (16 - LOG2D);
      lo = 18'd65536;
      hi = 18'd131071;
      for (int it = 0; it < 18; it++) begin
        if (lo < hi) begin
          mid = (lo + hi + 18'd1) >> 1;
          if (17'(sq_log2(mid[16:0])) <= tgt) lo = mid;
          else hi = mid - 18'd1;
        end
      end
      if (i == LOG_TABLE_DEPTH) t[i] = 18'd131072;
      else if (i == 0) t[i] = 18'd65536;
      else t[i] = lo;
    end
    return t;
  endfunction

  localparam tab_t LG_TAB = make_lg_tab();
  localparam tab_t EX_TAB = make_ex_tab();

endpackage

`default_nettype wire

// File: hdl/tesl_if.sv
// ----------------------------------------------------------------------------
// tesl_cmd_if / tesl_res_if
// Valid/ready channels for throttle commands and duty results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tesl_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] throttle;
  logic               brake;
  modport source (output valid, output throttle, output brake, input ready);
  modport sink   (input valid, input throttle, input brake, output ready);
endinterface

interface tesl_res_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] duty;
  logic               braking;
  logic [15:0]        brake_current;
  modport source (output valid, output duty, output braking, output brake_current,
                  input ready);
  modport sink   (input valid, input duty, input braking, input brake_current,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/throttle_expo_slew_limiter_unit.sv
// Sequence: a braking item raises its result in the cycle after acceptance; a throttle
// item steps through LG, LGW, Q, QW, EX, EXW, GAIN, GW, RAMP and OUT, where zero throttle
// starts at GAIN, deep attenuation skips EX and EXW and the dead zone skips GW. Items
// are handled one at a time; the next item is accepted in the cycle after the result
// is taken. The pace is set by the one shared multiplier, used for the log2
// interpolation, the exponent product, the exp2 interpolation and gain scaling in turn.
// Reset (synchronous, active high) restores the register defaults and zeroes the duty.
// ----------------------------------------------------------------------------
// throttle_expo_slew_limiter_unit
// Exponent throttle curve via log2/exp2 tables, gain scaling and slew limiting.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module throttle_expo_slew_limiter_unit
  import tesl_pkg::*;
#(
  parameter int MUL_A = MUL_A_W,
  parameter int MUL_B = MUL_B_W
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data,
  tesl_cmd_if.sink              cmd,
  tesl_res_if.source            res
);

  // Sequencer states. Each *_W state consumes the product that the multiplier
  // registered from the operands presented in the state before it.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LG   = 4'd1;
  localparam logic [3:0] S_LGW  = 4'd2;
  localparam logic [3:0] S_Q    = 4'd3;
  localparam logic [3:0] S_QW   = 4'd4;
  localparam logic [3:0] S_EX   = 4'd5;
  localparam logic [3:0] S_EXW  = 4'd6;
  localparam logic [3:0] S_GAIN = 4'd7;
  localparam logic [3:0] S_GW   = 4'd8;
  localparam logic [3:0] S_RAMP = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  localparam int N_W  = MUL_A + MUL_B - 24;
  localparam int SH_W = 18 + FRAC_BITS;

  // Configuration registers.
  logic [10:0] throttle_exponent;
  logic [15:0] forward_gain;
  logic [15:0] reverse_gain;
  logic [15:0] ramp_step;
  logic [15:0] brake_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_exponent <= 11'd256;
      forward_gain      <= 16'd32768;
      reverse_gain      <= 16'd16384;
      ramp_step         <= 16'd1638;
      brake_level       <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXPONENT: throttle_exponent <= cfg_data[10:0];
        REG_FWD_GAIN: forward_gain      <= cfg_data;
        REG_REV_GAIN: reverse_gain      <= cfg_data;
        REG_RAMP:     ramp_step         <= cfg_data;
        REG_BRAKE:    brake_level       <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0]                 state;
  logic [3:0]                 state_next;
  logic signed [DUTY_W-1:0]   cur;
  logic                       neg;
  logic [3:0]                 pidx;
  logic [16:0]                xarg;
  logic [L_W-1:0]             lval;
  logic [5:0]                 nval;
  logic [SHAPED_W-1:0]        shaped;
  logic signed [WIDE_W-1:0]   target;
  logic signed [DUTY_W-1:0]   duty_q;
  logic                       braking_q;
  logic [15:0]                brake_cur_q;

  // Command magnitude and leading-one position, taken at acceptance.
  logic [15:0] mag;
  logic [3:0]  lead;
  logic [31:0] norm;

  always_comb begin
    mag  = cmd.throttle[15] ? (16'd0 - cmd.throttle) : cmd.throttle;
    lead = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) lead = 4'(i);
    end
    norm = {16'd0, mag} << (5'd16 - {1'b0, lead});
  end

  // Table interpolation shared by the log2 and exp2 passes; the argument
  // sits in xarg and the table is chosen by the state.
  logic [LOG2D:0]  tidx;
  logic [LOG2D:0]  tidx_hi;
  logic            at_end;
  logic [15:0]     trem;
  logic [17:0]     t_lo;
  logic [17:0]     t_hi;
  logic [17:0]     t_diff;
  logic            use_lg;
  logic [MUL_A-1:0] mul_a;
  logic [MUL_B-1:0] mul_b;
  logic [MUL_A+MUL_B-1:0] prod;
  logic [17:0]     interp_val;

  always_comb begin
    tidx    = xarg[16 -: (LOG2D + 1)];
    at_end  = (tidx == (LOG2D+1)'(LOG_TABLE_DEPTH));
    tidx_hi = at_end ? tidx : tidx + (LOG2D+1)'(1);
    trem    = {xarg[15-LOG2D:0], {LOG2D{1'b0}}};
    use_lg  = (state == S_LG) || (state == S_LGW);
    t_lo    = use_lg ? LG_TAB[tidx] : EX_TAB[tidx];
    t_hi    = use_lg ? LG_TAB[tidx_hi] : EX_TAB[tidx_hi];
    t_diff  = t_hi - t_lo;
    interp_val = at_end ? t_lo : t_lo + prod[33:16];
  end

  always_comb begin
    unique case (state)
      S_LG, S_EX: begin
        mul_a = MUL_A'(t_diff);
        mul_b = MUL_B'(trem);
      end
      S_Q: begin
        mul_a = MUL_A'(lval);
        mul_b = MUL_B'(throttle_exponent);
      end
      S_GAIN: begin
        mul_a = MUL_A'(shaped);
        mul_b = neg ? reverse_gain : forward_gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tesl_mul #(.A_W(MUL_A), .B_W(MUL_B)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Exponent product split into integer and fraction parts.
  logic [N_W-1:0] qn;
  logic [15:0]    qg;
  logic [SH_W-1:0] sh_wide;
  logic [SHAPED_W+4:0] dz_val;
  logic            dead;
  logic [SHAPED_W:0] gmag;
  logic signed [WIDE_W-1:0] delta;
  logic signed [WIDE_W-1:0] ramp_w;
  logic signed [WIDE_W-1:0] nc;
  logic signed [WIDE_W-1:0] one_w;

  always_comb begin
    qn      = prod[MUL_A+MUL_B-1:24];
    qg      = prod[23:8];
    sh_wide = (SH_W'(interp_val) << FRAC_BITS) >> ({1'b0, nval} + 7'd17);
    dz_val  = (SHAPED_W+5)'({shaped, 4'd0}) + (SHAPED_W+5)'({shaped, 2'd0});
    dead    = dz_val < (SHAPED_W+5)'(1 << FRAC_BITS);
    gmag    = prod[15 +: (SHAPED_W + 1)];
    one_w   = WIDE_W'(1 << FRAC_BITS);
    ramp_w  = WIDE_W'({1'b0, ramp_step});
    delta   = target - WIDE_W'(cur);
    if (delta > ramp_w) delta = ramp_w;
    else if (delta < -ramp_w) delta = -ramp_w;
    nc = WIDE_W'(cur) + delta;
    if (nc > one_w) nc = one_w;
    if (nc < -one_w) nc = -one_w;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          if (cmd.brake) state_next = S_OUT;
          else if (mag == 16'd0) state_next = S_GAIN;
          else state_next = S_LG;
        end
      end
      S_LG:   state_next = S_LGW;
      S_LGW:  state_next = S_Q;
      S_Q:    state_next = S_QW;
      S_QW:   state_next = (qn >= N_W'(40)) ? S_GAIN : S_EX;
      S_EX:   state_next = S_EXW;
      S_EXW:  state_next = S_GAIN;
      S_GAIN: state_next = dead ? S_RAMP : S_GW;
      S_GW:   state_next = S_RAMP;
      S_RAMP: state_next = S_OUT;
      S_OUT:  state_next = res.ready ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && cmd.valid && cmd.brake) cur <= '0;
      if (state == S_RAMP) cur <= DUTY_W'(nc);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        neg         <= cmd.throttle[15];
        pidx        <= lead;
        xarg        <= {1'b0, norm[15:0]};
        shaped      <= '0;
        duty_q      <= '0;
        braking_q   <= cmd.brake;
        brake_cur_q <= cmd.brake ? brake_level : 16'd0;
      end
      S_LGW: begin
        lval <= {(L_W-16)'(FRAC_BITS) - (L_W-16)'(pidx), 16'd0} - L_W'(interp_val);
      end
      S_QW: begin
        nval <= qn[5:0];
        xarg <= 17'h10000 - {1'b0, qg};
      end
      S_EXW: shaped <= sh_wide[SHAPED_W-1:0];
      S_GAIN: target <= '0;
      S_GW: target <= neg ? -WIDE_W'(gmag) : WIDE_W'(gmag);
      S_RAMP: duty_q <= DUTY_W'(nc);
      default: ;
    endcase
  end

  assign cmd.ready         = (state == S_IDLE);
  assign res.valid         = (state == S_OUT);
  assign res.duty          = duty_q;
  assign res.braking       = braking_q;
  assign res.brake_current = brake_cur_q;

  // The stored duty never leaves plus or minus one.
  `TESL_ASSERT(a_duty_range, (cur <= DUTY_W'(1 << FRAC_BITS)) && (cur >= -DUTY_W'(1 << FRAC_BITS)), "duty out of range")
  // A braking result carries zero duty.
  `TESL_IMPLY(a_brake_duty, res.valid && res.braking, res.duty == '0, "braking with nonzero duty")
  // No brake current unless braking.
  `TESL_IMPLY(a_brake_cur, res.valid && !res.braking, res.brake_current == 16'd0, "stray brake current")
  // One item at a time: never ready while a result is pending.
  `TESL_IMPLY(a_one_item, res.valid, !cmd.ready, "ready with a pending result")

endmodule

`default_nettype wire

// File: hdl/tesl_mul.sv
// ----------------------------------------------------------------------------
// tesl_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tesl_mul
  import tesl_pkg::*;
#(
  parameter int A_W = MUL_A_W,
  parameter int B_W = MUL_B_W
) (
  input  wire                 clk,
  input  wire  [A_W-1:0]      a,
  input  wire  [B_W-1:0]      b,
  output logic [A_W+B_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

`default_nettype wire

// File: bench/tb_throttle_expo_slew_limiter_unit.sv
// ----------------------------------------------------------------------------
// tb_throttle_expo_slew_limiter_unit
// Self-checking bench: directed and random throttle items under several
// register settings, checked against a cycle-free duty predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_throttle_expo_slew_limiter_unit;
  import tesl_pkg::*;

  // An index past the last register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAB_N = 64;

  typedef struct {
    logic signed [16:0] duty;
    logic               braking;
    logic [15:0]        current;
  } duty_result_t;

  // Holds the expected duty results and the predictor state that makes them.
  class duty_scoreboard;
    longint unsigned log_tab[0:TAB_N];
    longint unsigned exp_tab[0:TAB_N];
    longint unsigned expo, fwd, rev, ramp, brake_ma;
    longint          held_duty;
    duty_result_t    pending_q[$];
    int              mismatches;

    function new();
      longint unsigned goal, lo, hi, mid;
      for (int i = 0; i <= TAB_N; i++) begin
        goal = (longint'(i) * 65536) / TAB_N;
        if (i == TAB_N) begin
          log_tab[i] = 65536;
          exp_tab[i] = 131072;
        end else begin
          log_tab[i] = mant_log2(65536 + goal);
          lo = 65536;
          hi = 131071;
          while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mant_log2(mid) <= goal) lo = mid;
            else hi = mid - 1;
          end
          exp_tab[i] = (i == 0) ? 65536 : lo;
        end
      end
      expo = 256; fwd = 32768; rev = 16384; ramp = 1638; brake_ma = 0;
      held_duty = 0;
      mismatches = 0;
    endfunction

    // Fractional log2 of a Q16 mantissa in [1, 2), by repeated squaring.
    function longint unsigned mant_log2(longint unsigned u);
      longint unsigned y, r;
      y = u;
      r = 0;
      for (int k = 15; k >= 0; k--) begin
        y = (y * y) >> 16;
        if (y >= 131072) begin
          y = y >> 1;
          r |= (64'd1 << k);
        end
      end
      return r;
    endfunction

    function longint unsigned lookup(bit is_exp, longint unsigned x);
      longint unsigned s, idx, rem, a, b;
      s = x * TAB_N;
      idx = s >> 16;
      rem = s & 16'hFFFF;
      if (idx >= TAB_N) return is_exp ? exp_tab[TAB_N] : log_tab[TAB_N];
      a = is_exp ? exp_tab[idx] : log_tab[idx];
      b = is_exp ? exp_tab[idx + 1] : log_tab[idx + 1];
      return a + (((b - a) * rem) >> 16);
    endfunction

    // Magnitude raised to the exponent, at Q1.15.
    function longint unsigned curve(longint unsigned m);
      int p;
      longint unsigned u, lf, l, q, n, g, e;
      if (m == 0) return 0;
      p = 0;
      while ((m >> (p + 1)) != 0) p++;
      u = m << (16 - p);
      lf = lookup(1'b0, (u - 65536) & 16'hFFFF);
      l = longint'(15 - p) * 65536 - lf;
      q = (l * expo) >> 8;
      n = q >> 16;
      g = q & 16'hFFFF;
      if (n >= 40) return 0;
      e = lookup(1'b1, 65536 - g);
      return (e << 15) >> (n + 17);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_EXPONENT: expo = 64'(val[10:0]);
        REG_FWD_GAIN: fwd = 64'(val);
        REG_REV_GAIN: rev = 64'(val);
        REG_RAMP:     ramp = 64'(val);
        REG_BRAKE:    brake_ma = 64'(val);
        default: ;
      endcase
    endfunction

    function void note_input(logic signed [15:0] thr, logic brk);
      duty_result_t r;
      longint unsigned mag, s;
      longint target, step;
      if (brk) begin
        held_duty = 0;
        r.duty = '0;
        r.braking = 1'b1;
        r.current = brake_ma[15:0];
      end else begin
        mag = (thr < 0) ? longint'(-longint'(thr)) : longint'(thr);
        s = curve(mag);
        target = 0;
        if (s * 20 >= 32768) begin
          if (thr < 0) target = -longint'((s * rev) >> 15);
          else target = longint'((s * fwd) >> 15);
        end
        step = target - held_duty;
        if (step > longint'(ramp)) step = ramp;
        else if (step < -longint'(ramp)) step = -longint'(ramp);
        held_duty = held_duty + step;
        if (held_duty > 32768) held_duty = 32768;
        if (held_duty < -32768) held_duty = -32768;
        r.duty = held_duty[16:0];
        r.braking = 1'b0;
        r.current = '0;
      end
      pending_q.push_back(r);
    endfunction

    function void check(logic signed [16:0] duty, logic braking, logic [15:0] current);
      duty_result_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: duty=%0d braking=%0b current=%0d",
                   duty, braking, current);
        return;
      end
      e = pending_q.pop_front();
      if (duty !== e.duty || braking !== e.braking || current !== e.current) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected duty=%0d braking=%0b current=%0d, got duty=%0d braking=%0b current=%0d",
                   e.duty, e.braking, e.current, duty, braking, current);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tesl_cmd_if cmd_ch ();
  tesl_res_if res_ch ();

  throttle_expo_slew_limiter_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd_ch), .res(res_ch)
  );

  duty_scoreboard sb = new();

  // The main process raises this to make the receiver hold off for a long stretch.
  bit hold_req = 1'b0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Both channels are sampled at the clock edge, before any of this edge's
  // nonblocking updates land, so the handshake view matches the block's.
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) sb.note_input(cmd_ch.throttle, cmd_ch.brake);
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check(res_ch.duty, res_ch.braking, res_ch.brake_current);
  end

  // Watchdog: a long run of cycles with no item moving on either side is a hang.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: the stall pattern switches at random between always ready,
  // coin flips and rare acceptance; a hold request stalls it for a long stretch.
  initial begin
    int mode;
    int held;
    res_ch.ready <= 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        held = 0;
        res_ch.ready <= 1'b0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_req = 1'b0;
      end
      if ($urandom_range(63, 0) == 0) mode = $urandom_range(2, 0);
      case (mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(1, 0));
        default: res_ch.ready <= ($urandom_range(3, 0) == 0);
      endcase
    end
  end

  // Offers one item and returns at the edge where it is taken. The valid line
  // stays high so that a following call continues the burst without a dip.
  task automatic offer(logic signed [15:0] thr, logic brk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.throttle <= thr;
    cmd_ch.brake <= brk;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Inserts a random gap when the current burst is used up.
  task automatic pace();
    int gap;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(20, 0);
    gap = $urandom_range(12, 1);
    cmd_ch.valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Stops offering until every expected result is back, then lets the block settle.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(int e, int fg, int rg, int rp, int bk);
    set_reg(REG_EXPONENT, e[15:0]);
    set_reg(REG_FWD_GAIN, fg[15:0]);
    set_reg(REG_REV_GAIN, rg[15:0]);
    set_reg(REG_RAMP, rp[15:0]);
    set_reg(REG_BRAKE, bk[15:0]);
  endtask

  // Random throttle: half the time full range, else weighted to the dead-zone edge,
  // tiny values and the two ends of the scale.
  function automatic logic signed [15:0] pick_throttle();
    int sel;
    int mag;
    sel = $urandom_range(9, 0);
    if (sel < 5) return 16'($urandom_range(65535, 0));
    if (sel < 7) mag = $urandom_range(3000, 800);
    else if (sel < 8) mag = $urandom_range(40, 0);
    else mag = $urandom_range(32767, 32600);
    return $urandom_range(1, 0) ? 16'(-mag) : 16'(mag);
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      offer(pick_throttle(), $urandom_range(11, 0) == 0);
      pace();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.throttle <= '0;
    cmd_ch.brake <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items under the reset defaults: zero, the scale ends, the
    // dead-zone edge, braking with the default current of zero, and recovery.
    offer(16'sd0, 1'b0);
    offer(16'sd32767, 1'b0);
    offer(16'sd32767, 1'b0);
    offer(-16'sd32768, 1'b0);
    offer(16'sd1, 1'b0);
    offer(-16'sd1, 1'b0);
    offer(16'sd1638, 1'b0);
    offer(16'sd1639, 1'b0);
    offer(-16'sd1639, 1'b0);
    offer(16'sd16384, 1'b1);
    offer(16'sd16384, 1'b0);
    drain();

    // Extreme settings: full ramp, largest brake current, gains above full
    // scale, and a write to an index past the last register.
    set_all(64, 65535, 65535, 65535, 65535);
    set_reg(REG_NONE, 16'h1234);
    offer(16'sd32767, 1'b0);
    offer(-16'sd32768, 1'b0);
    offer(16'sd100, 1'b0);
    offer(-16'sd32768, 1'b1);
    offer(-16'sd20000, 1'b0);
    drain();

    // Exponent zero gives full scale for any non-zero throttle; zero stays zero.
    set_all(0, 32768, 32768, 32768, 12345);
    offer(16'sd0, 1'b0);
    offer(16'sd1, 1'b0);
    offer(-16'sd1, 1'b0);
    offer(16'sd0, 1'b1);
    drain();

    // Largest exponent field and zero ramp: deep attenuation, frozen duty.
    set_all(2047, 0, 0, 0, 1);
    offer(16'sd32767, 1'b0);
    offer(-16'sd2, 1'b0);
    offer(16'sd30000, 1'b0);
    drain();

    // Random phases, each under its own settings.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_all(256, 32768, 16384, 1638, 0);
        1: set_all(1024, 32768, 32768, 32768, 65535);
        2: set_all(64, 0, 32768, 1, 500);
        default:
          set_all($urandom_range(1024, 64), $urandom_range(32768, 0),
                  $urandom_range(32768, 0), $urandom_range(32768, 0),
                  $urandom_range(65535, 0));
      endcase
      if (ph == 3) begin
        // The receiver stalls long while items keep coming back to back,
        // so the block fills and refuses further input.
        hold_req = 1'b1;
        no_gaps = 1'b1;
        random_items(40);
        no_gaps = 1'b0;
      end
      if (ph == 5) begin
        // A stretch with no sender gaps at all.
        no_gaps = 1'b1;
        random_items(150);
        no_gaps = 1'b0;
      end else begin
        random_items(180);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
